>>> rtl/ess_pkg.sv
// ----------------------------------------------------------------------------
// ess_pkg
// Shared types, byte codes and classifiers for the escape sequence stripper.
// ----------------------------------------------------------------------------
package ess_pkg;

    localparam int unsigned BYTE_W = 8;

    typedef logic [BYTE_W-1:0] byte_t;

    // Byte codes that steer the parser
    localparam byte_t ESC_CODE    = 8'h1B;
    localparam byte_t CSI_CODE    = 8'h5B;  // '['
    localparam byte_t KEYPAD_CODE = 8'h3D;  // '='
    localparam byte_t PAREN_CODE  = 8'h29;  // ')'
    localparam byte_t BANG_CODE   = 8'h21;  // '!'

    localparam byte_t SJIS_LO1    = 8'h81;
    localparam byte_t SJIS_HI1    = 8'h9F;
    localparam byte_t SJIS_LO2    = 8'hE0;
    localparam byte_t SJIS_HI2    = 8'hFC;
    localparam byte_t UPPER_A     = 8'h41;
    localparam byte_t UPPER_Z     = 8'h5A;
    localparam byte_t LOWER_A     = 8'h61;
    localparam byte_t LOWER_Z     = 8'h7A;

    // Fixed-length drop counts after ESC (bytes still to go after the second)
    localparam logic [1:0] DROP_KEYPAD = 2'd2;
    localparam logic [1:0] DROP_PAREN  = 2'd1;

    typedef struct packed {
        byte_t data_byte;
        logic  text_end;
    } item_t;

    typedef struct packed {
        byte_t out_byte;
        logic  byte_present;
        logic  stream_end;
    } res_t;

    // Parser to top: state visible for checking
    typedef struct packed {
        logic idle;
    } par_stat_t;

    // Output queue to top
    typedef struct packed {
        logic       space;
        logic [1:0] level;
    } buf_stat_t;

    function automatic logic is_sjis_lead(input byte_t b);
        return ((b >= SJIS_LO1) && (b <= SJIS_HI1)) ||
               ((b >= SJIS_LO2) && (b <= SJIS_HI2));
    endfunction

    function automatic logic is_ascii_letter(input byte_t b);
        return ((b >= UPPER_A) && (b <= UPPER_Z)) ||
               ((b >= LOWER_A) && (b <= LOWER_Z));
    endfunction

endpackage

>>> rtl/ess_if.sv
// ----------------------------------------------------------------------------
// ess_in_if / ess_out_if
// Valid/ready channels for text bytes in and stripped results out.
// ----------------------------------------------------------------------------
interface ess_in_if;
    logic                 valid;
    logic                 ready;
    ess_pkg::byte_t       data_byte;
    logic                 text_end;

    modport source (output valid, output data_byte, output text_end, input ready);
    modport sink   (input valid, input data_byte, input text_end, output ready);
endinterface

interface ess_out_if;
    logic                 valid;
    logic                 ready;
    ess_pkg::byte_t       out_byte;
    logic                 byte_present;
    logic                 stream_end;

    modport source (output valid, output out_byte, output byte_present,
                    output stream_end, input ready);
    modport sink   (input valid, input out_byte, input byte_present,
                    input stream_end, output ready);
endinterface

>>> rtl/ess_parser.sv
// ----------------------------------------------------------------------------
// ess_parser
// Escape sequence state machine: decides per byte whether it is kept.
// ----------------------------------------------------------------------------
module ess_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  ess_pkg::item_t     item,
    output logic               res_valid,
    output ess_pkg::res_t      res,
    output ess_pkg::par_stat_t stat
);
    import ess_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_ESC_SEEN  = 3'd1,
        MODE_IN_CSI    = 3'd2,
        MODE_CSI_TRAIL = 3'd3,
        MODE_DROPPING  = 3'd4
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [1:0] drop_reg, drop_next;
    logic       keep;
    byte_t      b;

    assign b = item.data_byte;

    always_comb
    begin
        mode_next = mode_reg;
        drop_next = drop_reg;
        keep      = 1'b0;
        unique case (mode_reg)
            MODE_ESC_SEEN:
            begin
                priority if (b == CSI_CODE)
                begin
                    mode_next = MODE_IN_CSI;
                end
                else if (b == KEYPAD_CODE)
                begin
                    mode_next = MODE_DROPPING;
                    drop_next = DROP_KEYPAD;
                end
                else if ((b == PAREN_CODE) || (b == BANG_CODE))
                begin
                    mode_next = MODE_DROPPING;
                    drop_next = DROP_PAREN;
                end
                else
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_IN_CSI:
            begin
                priority if (is_ascii_letter(b))
                begin
                    mode_next = MODE_IDLE;
                end
                else if (is_sjis_lead(b))
                begin
                    mode_next = MODE_CSI_TRAIL;
                end
                else
                begin
                    mode_next = MODE_IN_CSI;
                end
            end
            MODE_CSI_TRAIL:
            begin
                mode_next = MODE_IN_CSI;
            end
            MODE_DROPPING:
            begin
                if (drop_reg <= 2'd1)
                begin
                    drop_next = 2'd0;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    drop_next = drop_reg - 2'd1;
                end
            end
            default:
            begin
                // idle, and unreachable codes behave as idle
                if (b == ESC_CODE)
                begin
                    mode_next = MODE_ESC_SEEN;
                    drop_next = 2'd0;
                end
                else
                begin
                    mode_next = MODE_IDLE;
                    keep      = 1'b1;
                end
            end
        endcase
        if (item.text_end)
        begin
            mode_next = MODE_IDLE;
            drop_next = 2'd0;
        end
    end

    assign res_valid        = keep | item.text_end;
    assign res.out_byte     = keep ? b : '0;
    assign res.byte_present = keep;
    assign res.stream_end   = item.text_end;
    assign stat.idle        = (mode_reg == MODE_IDLE) && (drop_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            drop_reg <= 2'd0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            drop_reg <= drop_next;
        end
    end

endmodule

>>> rtl/ess_out_buf.sv
// ----------------------------------------------------------------------------
// ess_out_buf
// Two-entry result queue so the parser keeps running while a result waits.
// ----------------------------------------------------------------------------
module ess_out_buf
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ess_pkg::res_t      push_res,
    output ess_pkg::buf_stat_t stat,
    ess_out_if.source          result
);
    import ess_pkg::*;

    res_t       head_reg, head_next;
    res_t       tail_reg, tail_next;
    logic [1:0] level_reg, level_next;
    logic       pop;

    assign pop = result.valid && result.ready;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        level_next = level_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (level_reg == 2'd0)
                begin
                    head_next = push_res;
                end
                else
                begin
                    tail_next = push_res;
                end
                level_next = level_reg + 2'd1;
            end
            2'b01:
            begin
                head_next  = tail_reg;
                level_next = level_reg - 2'd1;
            end
            2'b11:
            begin
                if (level_reg == 2'd1)
                begin
                    head_next = push_res;
                end
                else
                begin
                    head_next = tail_reg;
                    tail_next = push_res;
                end
            end
            default:
            begin
                level_next = level_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 2'd0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign stat.space          = (level_reg < 2'd2);
    assign stat.level          = level_reg;
    assign result.valid        = (level_reg != 2'd0);
    assign result.out_byte     = head_reg.out_byte;
    assign result.byte_present = head_reg.byte_present;
    assign result.stream_end   = head_reg.stream_end;

endmodule

>>> rtl/escape_sequence_stripper_unit.sv
// ----------------------------------------------------------------------------
// escape_sequence_stripper_unit
// Strips terminal escape sequences from a Shift-JIS/ASCII byte stream.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while the result queue has room and passes on
// every byte outside an escape sequence; a byte flagged as the text end always
// yields one result marked stream_end, with or without a kept byte. Throughput
// is one byte per clock while the result side keeps taking. A result passes
// through the input register and then the two-entry result queue before it
// shows on the output; the queue also lets the input side keep running after
// the result side stalls, until the queue is full. Dropped bytes without the
// end flag produce nothing at the output.
module escape_sequence_stripper_unit
(
    input  logic       clk,
    input  logic       rst_n,
    ess_in_if.sink     text_stream,
    ess_out_if.source  clean_stream
);
    import ess_pkg::*;

    item_t     item_reg;
    logic      valid_reg;
    logic      advance;
    logic      res_valid;
    res_t      res;
    par_stat_t par_stat;
    buf_stat_t buf_stat;

    // stage advances only when the queue has room for a possible result
    assign advance           = valid_reg && buf_stat.space;
    assign text_stream.ready = !valid_reg || buf_stat.space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (text_stream.ready)
        begin
            valid_reg <= text_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_stream.valid && text_stream.ready)
        begin
            item_reg.data_byte <= text_stream.data_byte;
            item_reg.text_end  <= text_stream.text_end;
        end
    end

    ess_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item_reg),
        .res_valid (res_valid),
        .res       (res),
        .stat      (par_stat)
    );

    ess_out_buf u_out_buf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (advance && res_valid),
        .push_res (res),
        .stat     (buf_stat),
        .result   (clean_stream)
    );

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.text_end) |-> (res_valid && res.stream_end))
        else $error("end request without end result");

    a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.text_end) |=> par_stat.idle)
        else $error("parser not idle after end of text");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        buf_stat.level != 2'd3)
        else $error("result queue overfilled");

    a_dropped_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_valid && !res.byte_present) |-> (res.out_byte == '0))
        else $error("dropped result carries a byte");

endmodule
